@@ rtl/waypoint_go_to_goal_controller_top_assert.svh @@
// ----------------------------------------------------------------------------
// waypoint go-to-goal controller assertion macros
// Shared property shorthands for the modules that check their own logic.
// ----------------------------------------------------------------------------
`ifndef WAYPOINT_GO_TO_GOAL_CONTROLLER_TOP_ASSERT_SVH
`define WAYPOINT_GO_TO_GOAL_CONTROLLER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define WGTG_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define WGTG_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/wgtg_pkg.sv @@
// ----------------------------------------------------------------------------
// wgtg_pkg
// Widths, constants, types and helper functions of the go-to-goal controller.
// ----------------------------------------------------------------------------
package wgtg_pkg;

  // route and iteration counts
  localparam int ROUTE_LENGTH = 4;
  localparam int CORDIC_STEPS = 16;
  localparam int NUM_WP       = 4;

  // field widths
  localparam int POS_W  = 16;
  localparam int HDG_W  = 16;
  localparam int SPD_W  = 16;
  localparam int TURN_W = 24;
  localparam int FWD_W  = 18;
  localparam int IDX_W  = 2;
  localparam int GAIN_W = 16;
  localparam int TOL_W  = 16;
  localparam int WP_W   = 32;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // stream words
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_PAD_W  = OUT_DATA_W - TURN_W - FWD_W - IDX_W;
  localparam int OUT_USER_W = 1;

  // datapath widths
  localparam int D_W      = POS_W + 1;       // signed offset
  localparam int PRE_SH   = 8;               // cordic operand scaling
  localparam int CW       = D_W + PRE_SH + 3; // cordic x/y with gain headroom
  localparam int ZW       = 24;              // angle accumulator, Q.20
  localparam int ANG_W    = ZW - PRE_SH;     // rounded angle, Q3.12
  localparam int ATAN_FRAC = 20;
  localparam int CSW      = $clog2(CORDIC_STEPS);
  localparam int ERR_W    = 18;
  localparam int MUL_W    = 18;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int SQ_IN_W  = 2 * POS_W;       // one squared offset
  localparam int SUM_W    = SQ_IN_W + 1;     // sum of squares
  localparam int SQRT_ITERS = (SUM_W + 1) / 2;
  localparam int ROOT_W   = SQRT_ITERS;
  localparam int SQ_W     = SUM_W + 1;
  localparam int SQ_CNT_W = $clog2(SQRT_ITERS + 1);

  localparam logic [ZW-1:0] HALF_PI_Q20 = ZW'(1647099);

  // arctangent of 2^-i for the first steps, Q.20
  localparam logic [ZW-1:0] ATAN_LUT [8] = '{
    ZW'(823550), ZW'(486170), ZW'(256879), ZW'(130396),
    ZW'(65451),  ZW'(32757),  ZW'(16383),  ZW'(8192)
  };

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WP0   = 3'd0,
    REG_WP1   = 3'd1,
    REG_WP2   = 3'd2,
    REG_WP3   = 3'd3,
    REG_GAIN  = 3'd4,
    REG_TOL_X = 3'd5,
    REG_TOL_Y = 3'd6
  } cfg_reg_e;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_CORDIC,
    S_MULX,
    S_MULY,
    S_MULG,
    S_TURN,
    S_SQRT,
    S_DONE
  } ctrl_state_e;

  // status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

  // elementary angle for cordic step i, Q.20
  function automatic logic [ZW-1:0] wgtg_atan_step(input logic [CSW-1:0] i);
    int k;
    logic [ZW-1:0] v;
    k = int'(i);
    if (k < 8) begin
      v = ATAN_LUT[i[2:0]];
    end else if (k > ATAN_FRAC) begin
      v = '0;
    end else begin
      v = ZW'(1) << (ATAN_FRAC - k);
    end
    return v;
  endfunction

  // route index after an arrival, wrapping at the route length
  function automatic logic [IDX_W-1:0] wgtg_next_index(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] n;
    if (idx == IDX_W'(ROUTE_LENGTH - 1)) begin
      n = '0;
    end else begin
      n = idx + IDX_W'(1);
    end
    return n;
  endfunction

endpackage

@@ rtl/wgtg_cordic.sv @@
// ----------------------------------------------------------------------------
// wgtg_cordic
// Vectoring cordic for atan2, one rotation step per cycle on a shared adder set.
// ----------------------------------------------------------------------------
module wgtg_cordic import wgtg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [D_W-1:0]   dx_i,
  input  logic signed [D_W-1:0]   dy_i,
  output logic signed [ANG_W-1:0] angle_o,
  output unit_status_t            status_o
);

  logic signed [CW-1:0] x_q, x_d, y_q, y_d;
  logic signed [CW-1:0] x0, y0, xs, ys;
  logic        [ZW-1:0] z_q, z_d, z0, zsum, at;
  logic       [CSW-1:0] step_q, step_d;
  logic                 busy_q, busy_d, zero_q, zero_d, last;

  // scaled operands
  assign x0 = $signed({{(CW-D_W-PRE_SH){dx_i[D_W-1]}}, dx_i, {PRE_SH{1'b0}}});
  assign y0 = $signed({{(CW-D_W-PRE_SH){dy_i[D_W-1]}}, dy_i, {PRE_SH{1'b0}}});

  assign xs   = x_q >>> step_q;
  assign ys   = y_q >>> step_q;
  assign at   = wgtg_atan_step(step_q);
  assign last = (step_q == CSW'(CORDIC_STEPS - 1));

  // load with quadrant pre-rotation, then one micro-rotation per cycle
  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    step_d = step_q;
    busy_d = busy_q;
    zero_d = zero_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      zero_d = (dx_i == '0) && (dy_i == '0);
      if (x0 < 0) begin
        if (y0 >= 0) begin
          x_d = y0;
          y_d = -x0;
          z_d = HALF_PI_Q20;
        end else begin
          x_d = -y0;
          y_d = x0;
          z_d = -HALF_PI_Q20;
        end
      end else begin
        x_d = x0;
        y_d = y0;
        z_d = '0;
      end
    end else if (busy_q) begin
      if (!y_q[CW-1]) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + at;
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - at;
      end
      step_d = step_q + CSW'(1);
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    zero_q <= zero_d;
  end

  // round Q.20 to Q3.12, atan2 of a zero offset is zero
  assign zsum    = z_q + ZW'(128);
  assign angle_o = zero_q ? '0 : $signed(zsum[ZW-1:PRE_SH]);

  assign status_o.busy = busy_q;
  assign status_o.done = busy_q && last;

endmodule

@@ rtl/wgtg_mult.sv @@
// ----------------------------------------------------------------------------
// wgtg_mult
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module wgtg_mult import wgtg_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] p_o
);

  logic signed [PROD_W-1:0] p_q;

  // product register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

@@ rtl/wgtg_isqrt.sv @@
// ----------------------------------------------------------------------------
// wgtg_isqrt
// Restoring integer square root, two radicand bits per cycle, rounded to nearest.
// ----------------------------------------------------------------------------
module wgtg_isqrt import wgtg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [SUM_W-1:0]   s_i,
  output logic [ROOT_W-1:0]  root_o,
  output unit_status_t       status_o
);

  logic [SQ_W-1:0]     rem_q, rem_d, r_q, r_d, bit_q, bit_d, trial;
  logic [SQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d, rnd;

  assign trial = r_q + bit_q;
  assign rnd   = (cnt_q == SQ_CNT_W'(SQRT_ITERS));

  // one digit per cycle, then the rounding step
  always_comb begin
    rem_d  = rem_q;
    r_d    = r_q;
    bit_d  = bit_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = {1'b0, s_i};
      r_d    = '0;
      bit_d  = SQ_W'(1) << (2 * (SQRT_ITERS - 1));
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rnd) begin
        if (rem_q > r_q) begin
          r_d = r_q + SQ_W'(1);
        end
        busy_d = 1'b0;
      end else begin
        if (rem_q >= trial) begin
          rem_d = rem_q - trial;
          r_d   = (r_q >> 1) + bit_q;
        end else begin
          r_d = r_q >> 1;
        end
        bit_d = bit_q >> 2;
        cnt_d = cnt_q + SQ_CNT_W'(1);
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    r_q   <= r_d;
    bit_q <= bit_d;
  end

  assign root_o        = r_q[ROOT_W-1:0];
  assign status_o.busy = busy_q;
  assign status_o.done = busy_q && rnd;

endmodule

@@ rtl/waypoint_go_to_goal_controller_top.sv @@
// ----------------------------------------------------------------------------
// waypoint_go_to_goal_controller_top
// Proportional go-to-goal steering over a cyclic route of waypoints.
//
// channel   direction  contents
// s_axis    in         pose word: pos_x, pos_y, heading, measured_speed
// m_axis    out        command word: turn_rate, forward_speed, target_index
//                      tuser: reached
// cfg       in         register write: index, data
//
// a pose word runs from accept to result through the cordic loop, three
// multiplier passes and the 17-digit root loop, one after another under the
// sequencer; the next word is taken once the sequencer is back in idle.
// s_axis_tready_o is high only while the sequencer is idle; a finished result
// sits in the output register and a new word may be taken meanwhile.
// a result that is not taken holds the sequencer in its last state.
// reset is asynchronous, active low; the waypoint registers return to their default route.
// ----------------------------------------------------------------------------
`include "waypoint_go_to_goal_controller_top_assert.svh"

module waypoint_go_to_goal_controller_top import wgtg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // pos_x[15:0], pos_y[31:16], heading[47:32], measured_speed[63:48]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // turn_rate[23:0], forward_speed[41:24], target_index[43:42], zeros[47:44]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // reached[0]
  output logic [OUT_USER_W-1:0] m_axis_tuser_o,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  ctrl_state_e state_q, state_d;

  logic [WP_W-1:0]   wp_q [NUM_WP];
  logic [GAIN_W-1:0] gain_q;
  logic [TOL_W-1:0]  tol_x_q, tol_y_q;
  logic [IDX_W-1:0]  route_q;

  logic signed [D_W-1:0]   dx_q, dy_q, dx_d, dy_d;
  logic        [D_W-1:0]   adx_full, ady_full;
  logic        [POS_W-1:0] adx_q, ady_q;
  logic signed [HDG_W-1:0] hd_q;
  logic signed [SPD_W-1:0] spd_q;
  logic        [IDX_W-1:0] idx_q;
  logic                    reached_q;
  logic signed [ERR_W-1:0] err_q;
  logic [SQ_IN_W-1:0]      sqx_q;
  logic signed [TURN_W-1:0] turn_q;

  logic [WP_W-1:0]  wp_sel;
  logic [POS_W-1:0] pos_x, pos_y;

  logic signed [TURN_W-1:0] out_turn_q;
  logic signed [FWD_W-1:0]  out_fwd_q;
  logic [IDX_W-1:0]         out_index_q;
  logic                     out_reached_q, m_valid_q;

  logic in_acc, out_free, commit;
  logic cordic_start, sqrt_start, mul_en, err_load, sqx_load, turn_load, prep_load;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ANG_W-1:0]  angle;
  logic [SUM_W-1:0]         sq_sum;
  logic [ROOT_W-1:0]        root;
  logic signed [PROD_W-1:0] tsum, tsh;
  logic signed [TURN_W-1:0] turn_sat;
  logic signed [FWD_W-1:0]  fwd_val;
  unit_status_t             cordic_st, sqrt_st;

  // handshakes
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign cfg_ready_o     = 1'b1;

  // offsets to the current waypoint
  assign wp_sel = wp_q[route_q];
  assign pos_x  = s_axis_tdata_i[POS_W-1:0];
  assign pos_y  = s_axis_tdata_i[2*POS_W-1:POS_W];
  assign dx_d   = $signed({1'b0, wp_sel[WP_W-1:POS_W]}) - $signed({1'b0, pos_x});
  assign dy_d   = $signed({1'b0, wp_sel[POS_W-1:0]}) - $signed({1'b0, pos_y});

  assign adx_full = dx_q[D_W-1] ? D_W'(-dx_q) : D_W'(dx_q);
  assign ady_full = dy_q[D_W-1] ? D_W'(-dy_q) : D_W'(dy_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_acc) state_d = S_START;
      S_START:  state_d = S_CORDIC;
      S_CORDIC: if (cordic_st.done) state_d = S_MULX;
      S_MULX:   state_d = S_MULY;
      S_MULY:   state_d = S_MULG;
      S_MULG:   state_d = S_TURN;
      S_TURN:   state_d = S_SQRT;
      S_SQRT:   if (sqrt_st.done) state_d = S_DONE;
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    cordic_start = 1'b0;
    sqrt_start   = 1'b0;
    mul_en       = 1'b0;
    mul_a        = $signed({{(MUL_W-POS_W){1'b0}}, adx_q});
    mul_b        = $signed({{(MUL_W-POS_W){1'b0}}, adx_q});
    err_load     = 1'b0;
    sqx_load     = 1'b0;
    turn_load    = 1'b0;
    prep_load    = 1'b0;
    commit       = 1'b0;
    unique case (state_q)
      S_START: begin
        cordic_start = 1'b1;
        prep_load    = 1'b1;
      end
      S_MULX: begin
        mul_en   = 1'b1;
        err_load = 1'b1;
      end
      S_MULY: begin
        mul_en   = 1'b1;
        mul_a    = $signed({{(MUL_W-POS_W){1'b0}}, ady_q});
        mul_b    = $signed({{(MUL_W-POS_W){1'b0}}, ady_q});
        sqx_load = 1'b1;
      end
      S_MULG: begin
        mul_en     = 1'b1;
        mul_a      = MUL_W'(err_q);
        mul_b      = $signed({{(MUL_W-GAIN_W){1'b0}}, gain_q});
        sqrt_start = 1'b1;
      end
      S_TURN:  turn_load = 1'b1;
      S_DONE:  commit = out_free;
      default: ;
    endcase
  end

  // shared units
  wgtg_cordic u_cordic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cordic_start),
    .dx_i     (dx_q),
    .dy_i     (dy_q),
    .angle_o  (angle),
    .status_o (cordic_st)
  );

  wgtg_mult u_mult (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign sq_sum = {1'b0, sqx_q} + {1'b0, prod[SQ_IN_W-1:0]};

  wgtg_isqrt u_isqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (sqrt_start),
    .s_i      (sq_sum),
    .root_o   (root),
    .status_o (sqrt_st)
  );

  // turn rounding and saturation
  assign tsum = prod + PROD_W'(128);
  assign tsh  = tsum >>> 8;
  always_comb begin
    if (tsh[PROD_W-1:TURN_W-1] == '0 || tsh[PROD_W-1:TURN_W-1] == '1) begin
      turn_sat = tsh[TURN_W-1:0];
    end else if (tsh[PROD_W-1]) begin
      turn_sat = {1'b1, {(TURN_W-1){1'b0}}};
    end else begin
      turn_sat = {1'b0, {(TURN_W-1){1'b1}}};
    end
  end

  // forward command
  assign fwd_val = reached_q ? FWD_W'(spd_q) : $signed({{(FWD_W-ROOT_W){1'b0}}, root});

  // control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      route_q   <= '0;
      m_valid_q <= 1'b0;
      wp_q[0]   <= WP_W'(1342197760);
      wp_q[1]   <= WP_W'(2147504128);
      wp_q[2]   <= WP_W'(2147491840);
      wp_q[3]   <= WP_W'(1342185472);
      gain_q    <= GAIN_W'(2560);
      tol_x_q   <= TOL_W'(410);
      tol_y_q   <= TOL_W'(410);
    end else begin
      state_q <= state_d;
      if (commit) begin
        m_valid_q <= 1'b1;
        if (reached_q) begin
          route_q <= wgtg_next_index(idx_q);
        end
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_WP0, REG_WP1, REG_WP2, REG_WP3: wp_q[cfg_index_i[IDX_W-1:0]] <= cfg_data_i;
          REG_GAIN:  gain_q  <= cfg_data_i[GAIN_W-1:0];
          REG_TOL_X: tol_x_q <= cfg_data_i[TOL_W-1:0];
          REG_TOL_Y: tol_y_q <= cfg_data_i[TOL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // word payload and working registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      hd_q  <= $signed(s_axis_tdata_i[2*POS_W+HDG_W-1:2*POS_W]);
      spd_q <= $signed(s_axis_tdata_i[IN_DATA_W-1:IN_DATA_W-SPD_W]);
      idx_q <= route_q;
    end
    if (prep_load) begin
      adx_q     <= adx_full[POS_W-1:0];
      ady_q     <= ady_full[POS_W-1:0];
      reached_q <= (adx_full[POS_W-1:0] <= tol_x_q) && (ady_full[POS_W-1:0] <= tol_y_q);
    end
    if (err_load) begin
      err_q <= ERR_W'(angle) - ERR_W'(hd_q);
    end
    if (sqx_load) begin
      sqx_q <= prod[SQ_IN_W-1:0];
    end
    if (turn_load) begin
      turn_q <= turn_sat;
    end
    if (commit) begin
      out_turn_q    <= turn_q;
      out_fwd_q     <= fwd_val;
      out_index_q   <= idx_q;
      out_reached_q <= reached_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}}, out_index_q, out_fwd_q, out_turn_q};
  assign m_axis_tuser_o  = out_reached_q;

  // checks
  `WGTG_ASSERT_NEXT(a_busy_after_accept, in_acc, !s_axis_tready_o,
                    "sequencer still ready after taking a word")
  `WGTG_ASSERT_IMPL(a_route_follows_result, m_valid_q,
                    route_q == (out_reached_q ? wgtg_next_index(out_index_q) : out_index_q),
                    "route index does not match the pending result")
  `WGTG_ASSERT_IMPL(a_distance_nonneg, m_valid_q && !out_reached_q, !out_fwd_q[FWD_W-1],
                    "negative distance in a pending result")
  `WGTG_ASSERT_IMPL(a_units_exclusive, cordic_st.busy, !sqrt_st.busy,
                    "cordic and square root running together")

endmodule
